[hw/rtl/packet_attack_filter_blacklist_defines.svh]
// Assertion helpers shared by the filter modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef PACKET_ATTACK_FILTER_BLACKLIST_DEFINES_SVH
`define PACKET_ATTACK_FILTER_BLACKLIST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PAFB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pafb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PAFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pafb: next-cycle check failed");

`endif

[hw/rtl/pafb_pkg.sv]
`timescale 1ns / 1ps

package pafb_pkg;

    // Packet class codes.
    typedef enum logic [2:0] {
        CLS_ARP   = 3'd0,
        CLS_ICMP  = 3'd1,
        CLS_IGMP  = 3'd2,
        CLS_TCP   = 3'd3,
        CLS_UDP   = 3'd4,
        CLS_OTHER = 3'd5,
        CLS_UNCL  = 3'd6
    } cls_t;

    // Verdict codes.
    typedef enum logic [2:0] {
        VERD_ACCEPT      = 3'd0,
        VERD_BLACKLISTED = 3'd1,
        VERD_LAND        = 3'd2,
        VERD_PORT_SCAN   = 3'd3,
        VERD_BAD_FLAGS   = 3'd4,
        VERD_TSUNAMI     = 3'd5,
        VERD_NOT_IP      = 3'd6,
        VERD_TRUNCATED   = 3'd7
    } verd_t;

    // Configuration register addresses.
    localparam logic [1:0] ADDR_SIZE_THRESHOLD = 2'd0;
    localparam logic [15:0] SIZE_THRESHOLD_RST = 16'd80;

    // Ethertypes.
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;

    // IP protocol numbers.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Frame byte positions.
    localparam logic [6:0] POS_ETYPE_HI = 7'd12;
    localparam logic [6:0] POS_ETYPE_LO = 7'd13;
    localparam logic [6:0] POS_IHL      = 7'd14;
    localparam logic [6:0] POS_L4_MIN   = 7'd15;
    localparam logic [6:0] POS_TLEN_HI  = 7'd16;
    localparam logic [6:0] POS_TLEN_LO  = 7'd17;
    localparam logic [6:0] POS_PROTO    = 7'd23;
    localparam logic [6:0] POS_SRC0     = 7'd26;
    localparam logic [6:0] POS_SRC1     = 7'd27;
    localparam logic [6:0] POS_SRC2     = 7'd28;
    localparam logic [6:0] POS_SRC3     = 7'd29;
    localparam logic [6:0] POS_DST0     = 7'd30;
    localparam logic [6:0] POS_DST1     = 7'd31;
    localparam logic [6:0] POS_DST2     = 7'd32;
    localparam logic [6:0] POS_DST3     = 7'd33;
    localparam logic [6:0] POS_MAX      = 7'd127;
    localparam logic [6:0] L4_OFFSET    = 7'd14;
    localparam logic [6:0] OFS_PORT_HI  = 7'd2;
    localparam logic [6:0] OFS_PORT_LO  = 7'd3;
    localparam logic [6:0] OFS_FLAGS    = 7'd13;

    // Allowed destination ports.
    localparam logic [15:0] PORT_FTP_DATA = 16'd20;
    localparam logic [15:0] PORT_FTP      = 16'd21;
    localparam logic [15:0] PORT_SSH      = 16'd22;
    localparam logic [15:0] PORT_DNS      = 16'd53;
    localparam logic [15:0] PORT_HTTP     = 16'd80;
    localparam logic [15:0] PORT_HTTPS    = 16'd443;

    // TCP flag patterns.
    localparam logic [5:0] FLAGS_NULL    = 6'h00;
    localparam logic [5:0] FLAGS_XMAS    = 6'h29;
    localparam logic [5:0] FLAGS_PSH     = 6'h08;
    localparam logic [5:0] FLAGS_ACK     = 6'h10;
    localparam logic [5:0] FLAGS_PSH_ACK = 6'h18;

    // Snapshot of one finished frame, partly decoded.
    typedef struct packed {
        logic        short_hdr;
        logic        is_arp;
        logic        is_ip;
        cls_t        pkt_class;
        logic        flags_seen;
        logic        port_ok;
        logic        flags_bad;
        logic        flags_pshack;
        logic        land;
        logic [15:0] ip_len;
        logic [31:0] src_addr;
    } eval_t;

    // One result item.
    typedef struct packed {
        cls_t        pkt_class;
        verd_t       verdict;
        logic [31:0] source_addr;
        logic        added;
    } res_t;

endpackage

[hw/rtl/packet_attack_filter_blacklist.sv]
`timescale 1ns / 1ps
`include "packet_attack_filter_blacklist_defines.svh"

// Byte-stream packet filter. One frame byte is taken per clock while input is
// not stalled, starting at the destination MAC. On the byte marked last, the
// captured header fields are snapshotted into a register; the verdict, class
// and source address are then registered into the output buffer once it has a
// free slot. The blacklist is a CAM of LIST_DEPTH entries searched in parallel;
// port-scan, bad-flag and tsunami verdicts insert the source, replacing the
// oldest entry once the list is full. Results queue in a two-entry output
// buffer; input is stalled only when that buffer is full and a finished frame
// is waiting for it.
// The size threshold register (byte address 0) should be written while idle.
module packet_attack_filter_blacklist
    import pafb_pkg::*;
#(
    parameter int LIST_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  pkt_class,
    output logic [2:0]  verdict,
    output logic [31:0] source_addr,
    output logic        added_to_list,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] size_threshold_reg;
    logic        eval_valid;
    logic        eval_move;
    eval_t       eval_data;
    logic        cam_hit;
    logic        q_room;
    res_t        res;
    res_t        head;

    // Configuration register access.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SIZE_THRESHOLD) ? {16'd0, size_threshold_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_threshold_reg <= SIZE_THRESHOLD_RST;
        else if (psel && penable && pwrite && pready && (paddr == ADDR_SIZE_THRESHOLD))
            size_threshold_reg <= pwdata[15:0];
    end

    // Field capture and frame snapshot.
    pafb_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .eval_move  (eval_move),
        .eval_valid (eval_valid),
        .eval_data  (eval_data)
    );

    // A snapshot moves on once the output buffer has a free slot.
    assign eval_move = eval_valid && q_room;

    // Blacklist lookup and insertion.
    pafb_cam #(
        .DEPTH (LIST_DEPTH)
    ) u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (eval_data.src_addr),
        .hit        (cam_hit),
        .ins_en     (eval_move && res.added),
        .ins_key    (eval_data.src_addr)
    );

    // Verdict logic.
    pafb_judge u_judge (
        .eval_data      (eval_data),
        .cam_hit        (cam_hit),
        .size_threshold (size_threshold_reg),
        .res            (res)
    );

    // Result buffer.
    pafb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (eval_move),
        .push_data (res),
        .room      (q_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign pkt_class     = head.pkt_class;
    assign verdict       = head.verdict;
    assign source_addr   = head.source_addr;
    assign added_to_list = head.added;

    `PAFB_ASSERT_IMPL(a_added_cause, eval_valid && res.added,
        res.verdict == VERD_PORT_SCAN || res.verdict == VERD_BAD_FLAGS ||
        res.verdict == VERD_TSUNAMI)
    `PAFB_ASSERT_IMPL(a_listed_not_added, eval_valid && cam_hit && eval_data.is_ip,
        !res.added)

endmodule

[hw/rtl/pafb_capture.sv]
`timescale 1ns / 1ps

module pafb_capture
    import pafb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        eval_move,
    output logic        eval_valid,
    output eval_t       eval_data
);

    logic [6:0]  byte_count_reg,    byte_count_next;
    logic [3:0]  header_words_reg,  header_words_next;
    logic [15:0] ether_kind_reg,    ether_kind_next;
    logic [7:0]  ip_proto_reg,      ip_proto_next;
    logic [15:0] ip_total_len_reg,  ip_total_len_next;
    logic [31:0] src_addr_reg,      src_addr_next;
    logic [31:0] dst_addr_reg,      dst_addr_next;
    logic [15:0] dest_port_reg,     dest_port_next;
    logic [5:0]  tcp_flag_bits_reg, tcp_flag_bits_next;
    logic        flags_seen_reg,    flags_seen_next;
    logic        eval_valid_reg,    eval_valid_next;
    eval_t       eval_reg,          eval_next;
    logic [6:0]  l4_start;
    logic        accept;

    assign in_stall   = eval_valid_reg && !eval_move;
    assign accept     = in_valid && !in_stall;
    assign eval_valid = eval_valid_reg;
    assign eval_data  = eval_reg;

    // Start of the header that follows the IP header.
    assign l4_start = L4_OFFSET + {1'b0, header_words_reg, 2'b00};

    // Field capture by byte position.
    always_comb
    begin
        header_words_next  = header_words_reg;
        ether_kind_next    = ether_kind_reg;
        ip_proto_next      = ip_proto_reg;
        ip_total_len_next  = ip_total_len_reg;
        src_addr_next      = src_addr_reg;
        dst_addr_next      = dst_addr_reg;
        dest_port_next     = dest_port_reg;
        tcp_flag_bits_next = tcp_flag_bits_reg;
        flags_seen_next    = flags_seen_reg;

        case (byte_count_reg)
            POS_ETYPE_HI: ether_kind_next[15:8]   = data_byte;
            POS_ETYPE_LO: ether_kind_next[7:0]    = data_byte;
            POS_IHL:      header_words_next       = data_byte[3:0];
            POS_TLEN_HI:  ip_total_len_next[15:8] = data_byte;
            POS_TLEN_LO:  ip_total_len_next[7:0]  = data_byte;
            POS_PROTO:    ip_proto_next           = data_byte;
            POS_SRC0:     src_addr_next[31:24]    = data_byte;
            POS_SRC1:     src_addr_next[23:16]    = data_byte;
            POS_SRC2:     src_addr_next[15:8]     = data_byte;
            POS_SRC3:     src_addr_next[7:0]      = data_byte;
            POS_DST0:     dst_addr_next[31:24]    = data_byte;
            POS_DST1:     dst_addr_next[23:16]    = data_byte;
            POS_DST2:     dst_addr_next[15:8]     = data_byte;
            POS_DST3:     dst_addr_next[7:0]      = data_byte;
            default:      ;
        endcase

        // Port and flag bytes may overlap the IP fields when the header length is below five words.
        if (byte_count_reg >= POS_L4_MIN)
        begin
            if (byte_count_reg == l4_start + OFS_PORT_HI)
                dest_port_next[15:8] = data_byte;
            if (byte_count_reg == l4_start + OFS_PORT_LO)
                dest_port_next[7:0] = data_byte;
            if (byte_count_reg == l4_start + OFS_FLAGS)
            begin
                tcp_flag_bits_next = data_byte[5:0];
                flags_seen_next    = 1'b1;
            end
        end

        if (byte_count_reg == POS_MAX)
            byte_count_next = byte_count_reg;
        else
            byte_count_next = byte_count_reg + 7'd1;
    end

    // Decode of the finished frame, taken on the last byte.
    always_comb
    begin
        eval_next.short_hdr  = byte_count_reg < POS_ETYPE_LO;
        eval_next.is_arp     = ether_kind_next == ETH_ARP;
        eval_next.is_ip      = ether_kind_next == ETH_IPV4;
        eval_next.flags_seen = flags_seen_next;
        eval_next.ip_len     = ip_total_len_next;
        eval_next.src_addr   = src_addr_next;
        eval_next.land       = src_addr_next == dst_addr_next;
        eval_next.port_ok    = dest_port_next inside {PORT_FTP_DATA, PORT_FTP, PORT_SSH,
                                                      PORT_DNS, PORT_HTTP, PORT_HTTPS};
        eval_next.flags_bad    = tcp_flag_bits_next inside {FLAGS_XMAS, FLAGS_NULL};
        eval_next.flags_pshack = tcp_flag_bits_next inside {FLAGS_PSH, FLAGS_ACK,
                                                            FLAGS_PSH_ACK};
        case (ip_proto_next)
            PROTO_ICMP: eval_next.pkt_class = CLS_ICMP;
            PROTO_IGMP: eval_next.pkt_class = CLS_IGMP;
            PROTO_TCP:  eval_next.pkt_class = CLS_TCP;
            PROTO_UDP:  eval_next.pkt_class = CLS_UDP;
            default:    eval_next.pkt_class = CLS_OTHER;
        endcase
    end

    // The snapshot register holds a frame until the judge stage takes it.
    always_comb
    begin
        if (accept && last_byte)
            eval_valid_next = 1'b1;
        else if (eval_move)
            eval_valid_next = 1'b0;
        else
            eval_valid_next = eval_valid_reg;
    end

    // Frame state; cleared after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            header_words_reg  <= '0;
            ether_kind_reg    <= '0;
            ip_proto_reg      <= '0;
            ip_total_len_reg  <= '0;
            src_addr_reg      <= '0;
            dst_addr_reg      <= '0;
            dest_port_reg     <= '0;
            tcp_flag_bits_reg <= '0;
            flags_seen_reg    <= 1'b0;
            eval_valid_reg    <= 1'b0;
        end
        else
        begin
            eval_valid_reg <= eval_valid_next;
            if (accept)
            begin
                if (last_byte)
                begin
                    byte_count_reg    <= '0;
                    header_words_reg  <= '0;
                    ether_kind_reg    <= '0;
                    ip_proto_reg      <= '0;
                    ip_total_len_reg  <= '0;
                    src_addr_reg      <= '0;
                    dst_addr_reg      <= '0;
                    dest_port_reg     <= '0;
                    tcp_flag_bits_reg <= '0;
                    flags_seen_reg    <= 1'b0;
                end
                else
                begin
                    byte_count_reg    <= byte_count_next;
                    header_words_reg  <= header_words_next;
                    ether_kind_reg    <= ether_kind_next;
                    ip_proto_reg      <= ip_proto_next;
                    ip_total_len_reg  <= ip_total_len_next;
                    src_addr_reg      <= src_addr_next;
                    dst_addr_reg      <= dst_addr_next;
                    dest_port_reg     <= dest_port_next;
                    tcp_flag_bits_reg <= tcp_flag_bits_next;
                    flags_seen_reg    <= flags_seen_next;
                end
            end
        end
    end

    // Snapshot payload.
    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
            eval_reg <= eval_next;
    end

endmodule

[hw/rtl/pafb_cam.sv]
`timescale 1ns / 1ps
`include "packet_attack_filter_blacklist_defines.svh"

module pafb_cam
    import pafb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] lookup_key,
    output logic        hit,
    input  logic        ins_en,
    input  logic [31:0] ins_key
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [31:0]      entries_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [DEPTH-1:0] hit_vec;

    // Compare every valid entry against the key in parallel.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            hit_vec[i] = valid_reg[i] && (entries_reg[i] == lookup_key);
    end

    assign hit = |hit_vec;

    // Oldest-first replacement pointer.
    assign ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else if (ins_en)
        begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= ptr_next;
        end
    end

    // Entry storage; unwritten entries are masked by their valid bits.
    always_ff @(posedge clk)
    begin
        if (ins_en)
            entries_reg[ptr_reg] <= ins_key;
    end

    `PAFB_ASSERT_NEXT(a_insert_kept, ins_en,
        valid_reg[$past(ptr_reg)] && (entries_reg[$past(ptr_reg)] == $past(ins_key)))

endmodule

[hw/rtl/pafb_judge.sv]
`timescale 1ns / 1ps

module pafb_judge
    import pafb_pkg::*;
(
    input  eval_t       eval_data,
    input  logic        cam_hit,
    input  logic [15:0] size_threshold,
    output res_t        res
);

    // Checks in priority order; only the last three add to the list.
    always_comb
    begin
        res.added       = 1'b0;
        res.source_addr = '0;
        res.verdict     = VERD_ACCEPT;
        res.pkt_class   = CLS_UNCL;
        if (eval_data.short_hdr)
        begin
            res.pkt_class = CLS_UNCL;
            res.verdict   = VERD_TRUNCATED;
        end
        else if (eval_data.is_arp)
        begin
            res.pkt_class = CLS_ARP;
            res.verdict   = VERD_NOT_IP;
        end
        else if (!eval_data.is_ip)
        begin
            res.pkt_class = CLS_UNCL;
            res.verdict   = VERD_NOT_IP;
        end
        else
        begin
            res.pkt_class   = eval_data.pkt_class;
            res.source_addr = eval_data.src_addr;
            if (!eval_data.flags_seen)
                res.verdict = VERD_TRUNCATED;
            else if (cam_hit)
                res.verdict = VERD_BLACKLISTED;
            else if (eval_data.land)
                res.verdict = VERD_LAND;
            else if (!eval_data.port_ok)
            begin
                res.verdict = VERD_PORT_SCAN;
                res.added   = 1'b1;
            end
            else if (eval_data.flags_bad)
            begin
                res.verdict = VERD_BAD_FLAGS;
                res.added   = 1'b1;
            end
            else if (!eval_data.flags_pshack && (eval_data.ip_len > size_threshold))
            begin
                res.verdict = VERD_TSUNAMI;
                res.added   = 1'b1;
            end
        end
    end

endmodule

[hw/rtl/pafb_outq.sv]
`timescale 1ns / 1ps
`include "packet_attack_filter_blacklist_defines.svh"

module pafb_outq
    import pafb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic room,
    output logic out_valid,
    input  logic out_stall,
    output res_t head
);

    logic [1:0] count_reg, count_next;
    res_t       slot0_reg, slot1_reg;
    logic       pop;

    assign room      = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign head      = slot0_reg;

    // Occupancy count.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Slot 0 is the head; slot 1 holds a result while the head is stalled.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && (count_reg == 2'd1))
                slot0_reg <= push_data;
            else
                slot0_reg <= slot1_reg;
            if (push && (count_reg == 2'd2))
                slot1_reg <= push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                slot0_reg <= push_data;
            else
                slot1_reg <= push_data;
        end
    end

    `PAFB_ASSERT_IMPL(a_no_overflow, push, count_reg != 2'd2)
    `PAFB_ASSERT_NEXT(a_drain_one, pop && !push, count_reg == $past(count_reg) - 2'd1)

endmodule

[dv/verdict_checker.sv]
`timescale 1ns / 1ps

// Watches both streams and the register port of the packet filter, works out
// the verdict of every frame from its bytes and compares each result transfer
// with the oldest verdict still due.
module verdict_checker
    import pafb_pkg::*;
#(
    parameter int LIST_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  pkt_class,
    input  logic [2:0]  verdict,
    input  logic [31:0] source_addr,
    input  logic        added_to_list,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending,
    output int          checked,
    output int          inserts
);

    // Mirror of the filter's register and per-frame capture state.
    logic [15:0] threshold;
    logic [6:0]  pos_cnt;
    logic [3:0]  ihl;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [15:0] tlen;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] dport;
    logic [5:0]  flags;
    logic        flags_got;

    // Mirror of the blacklist CAM, filled in arrival order.
    logic [31:0] deny_addr [LIST_DEPTH];
    logic        deny_used [LIST_DEPTH];
    int          deny_next;

    res_t verdicts_due[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic bit port_allowed(input logic [15:0] p);
        return p == PORT_FTP_DATA || p == PORT_FTP || p == PORT_SSH ||
               p == PORT_DNS || p == PORT_HTTP || p == PORT_HTTPS;
    endfunction

    function void clear_frame();
        pos_cnt   = '0;
        ihl       = '0;
        etype     = '0;
        proto     = '0;
        tlen      = '0;
        src_ip    = '0;
        dst_ip    = '0;
        dport     = '0;
        flags     = '0;
        flags_got = 1'b0;
    endfunction

    function bit on_deny_list(input logic [31:0] a);
        for (int i = 0; i < LIST_DEPTH; i++)
            if (deny_used[i] && deny_addr[i] == a)
                return 1'b1;
        return 1'b0;
    endfunction

    // Capture by byte position; the layer-4 offsets follow the IHL seen so far.
    function void capture_byte(input int pos, input logic [7:0] b);
        int s;
        s = int'(L4_OFFSET) + 4 * int'(ihl);
        if (pos == POS_ETYPE_HI) etype[15:8] = b;
        if (pos == POS_ETYPE_LO) etype[7:0] = b;
        if (pos == POS_IHL) ihl = b[3:0];
        if (pos == POS_TLEN_HI) tlen[15:8] = b;
        if (pos == POS_TLEN_LO) tlen[7:0] = b;
        if (pos == POS_PROTO) proto = b;
        if (pos >= POS_SRC0 && pos <= POS_SRC3)
            src_ip[8 * (int'(POS_SRC3) - pos) +: 8] = b;
        if (pos >= POS_DST0 && pos <= POS_DST3)
            dst_ip[8 * (int'(POS_DST3) - pos) +: 8] = b;
        if (pos >= POS_L4_MIN)
        begin
            if (pos == s + OFS_PORT_HI) dport[15:8] = b;
            if (pos == s + OFS_PORT_LO) dport[7:0] = b;
            if (pos == s + OFS_FLAGS)
            begin
                flags     = b[5:0];
                flags_got = 1'b1;
            end
        end
    endfunction

    // Verdict of the frame whose last byte sat at position pos.
    function res_t finish_frame(input int pos);
        res_t  r;
        cls_t  c;
        verd_t v;
        logic  add;
        c   = CLS_UNCL;
        v   = VERD_ACCEPT;
        add = 1'b0;
        r.source_addr = '0;
        if (pos < POS_ETYPE_LO)
            v = VERD_TRUNCATED;
        else if (etype == ETH_ARP)
        begin
            c = CLS_ARP;
            v = VERD_NOT_IP;
        end
        else if (etype != ETH_IPV4)
            v = VERD_NOT_IP;
        else
        begin
            case (proto)
                PROTO_ICMP: c = CLS_ICMP;
                PROTO_IGMP: c = CLS_IGMP;
                PROTO_TCP:  c = CLS_TCP;
                PROTO_UDP:  c = CLS_UDP;
                default:    c = CLS_OTHER;
            endcase
            r.source_addr = src_ip;
            if (!flags_got)
                v = VERD_TRUNCATED;
            else if (on_deny_list(src_ip))
                v = VERD_BLACKLISTED;
            else if (dst_ip == src_ip)
                v = VERD_LAND;
            else if (!port_allowed(dport))
            begin
                v   = VERD_PORT_SCAN;
                add = 1'b1;
            end
            else if (flags == FLAGS_XMAS || flags == FLAGS_NULL)
            begin
                v   = VERD_BAD_FLAGS;
                add = 1'b1;
            end
            else if (flags != FLAGS_PSH && flags != FLAGS_ACK && flags != FLAGS_PSH_ACK &&
                     tlen > threshold)
            begin
                v   = VERD_TSUNAMI;
                add = 1'b1;
            end
            // The oldest entry is overwritten once the list has wrapped.
            if (add)
            begin
                deny_addr[deny_next] = src_ip;
                deny_used[deny_next] = 1'b1;
                deny_next = (deny_next + 1) % LIST_DEPTH;
                inserts++;
            end
        end
        r.pkt_class = c;
        r.verdict   = v;
        r.added     = add;
        clear_frame();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        res_t want;
        int   pos;
        if (!rst_n)
        begin
            clear_frame();
            threshold = SIZE_THRESHOLD_RST;
            deny_next = 0;
            for (int i = 0; i < LIST_DEPTH; i++)
                deny_used[i] = 1'b0;
            verdicts_due.delete();
            errors  = 0;
            pending = 0;
            checked = 0;
            inserts = 0;
        end
        else
        begin
            // Register port: track writes, check reads.
            if (psel && penable && pready && paddr == ADDR_SIZE_THRESHOLD)
            begin
                if (pwrite)
                    threshold = pwdata[15:0];
                else if (prdata !== {16'h0, threshold})
                    report_mismatch("size threshold readback", prdata, {16'h0, threshold});
            end

            // Result transfer against the oldest verdict due.
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch("result with nothing due, verdict", verdict, '0);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (pkt_class !== want.pkt_class)
                        report_mismatch("pkt_class", pkt_class, want.pkt_class);
                    if (verdict !== want.verdict)
                        report_mismatch("verdict", verdict, want.verdict);
                    if (source_addr !== want.source_addr)
                        report_mismatch("source_addr", source_addr, want.source_addr);
                    if (added_to_list !== want.added)
                        report_mismatch("added_to_list", added_to_list, want.added);
                    checked++;
                end
            end

            // Byte transfer into the predictor.
            if (in_valid && !in_stall)
            begin
                pos = int'(pos_cnt);
                capture_byte(pos, data_byte);
                if (pos_cnt < POS_MAX)
                    pos_cnt++;
                if (last_byte)
                    verdicts_due.push_back(finish_frame(pos));
            end
            pending = verdicts_due.size();
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

// Frame stimulus for the packet filter: directed corner frames, then random
// well-formed, truncated and malformed frames under several size thresholds,
// with random gaps on the byte stream and random stalls on the results.
module tb;
    import pafb_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_FRAMES   = 1;

    typedef struct {
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [15:0] tlen;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] dport;
        logic [7:0]  flags;
        int          len;
    } frame_spec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  pkt_class;
    logic [2:0]  verdict;
    logic [31:0] source_addr;
    logic        added_to_list;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int chk_errors;
    int chk_pending;
    int chk_checked;
    int chk_inserts;

    logic [7:0]  frame[$];
    logic [31:0] addr_pool[8];
    logic [15:0] ok_ports[6] = '{PORT_FTP_DATA, PORT_FTP, PORT_SSH,
                                 PORT_DNS, PORT_HTTP, PORT_HTTPS};
    logic [5:0]  flag_picks[5] = '{FLAGS_PSH_ACK, FLAGS_ACK, FLAGS_PSH,
                                   FLAGS_XMAS, FLAGS_NULL};
    logic [7:0]  proto_picks[4] = '{PROTO_ICMP, PROTO_IGMP, PROTO_TCP, PROTO_UDP};
    logic [15:0] cur_threshold = SIZE_THRESHOLD_RST;
    int          frames_sent = 0;
    int          bytes_sent = 0;
    int          gap_max = 0;
    int          burst_left = 0;
    int          settings_used = 1;
    bit          hold_request = 1'b0;

    packet_attack_filter_blacklist dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pkt_class     (pkt_class),
        .verdict       (verdict),
        .source_addr   (source_addr),
        .added_to_list (added_to_list),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    verdict_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pkt_class     (pkt_class),
        .verdict       (verdict),
        .source_addr   (source_addr),
        .added_to_list (added_to_list),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (chk_errors),
        .pending       (chk_pending),
        .checked       (chk_checked),
        .inserts       (chk_inserts)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Base IPv4/TCP frame with a 20-byte IP header, ending on the TCP flags byte.
    function automatic frame_spec_t ip_frame(input logic [31:0] src, input logic [31:0] dst,
                                             input logic [15:0] dport,
                                             input logic [7:0] flags);
        frame_spec_t f;
        f.etype   = ETH_IPV4;
        f.ver_ihl = 8'h45;
        f.tlen    = 16'd60;
        f.proto   = PROTO_TCP;
        f.src     = src;
        f.dst     = dst;
        f.dport   = dport;
        f.flags   = flags;
        f.len     = 48;
        return f;
    endfunction

    function void put_byte(input int pos, input logic [7:0] v);
        if (pos < frame.size())
            frame[pos] = v;
    endfunction

    // Random bytes with the header fields laid over them at their positions.
    function void compose(input frame_spec_t f);
        int s;
        frame.delete();
        for (int i = 0; i < f.len; i++)
            frame.push_back(8'($urandom_range(0, 255)));
        s = int'(L4_OFFSET) + 4 * int'(f.ver_ihl[3:0]);
        put_byte(POS_ETYPE_HI, f.etype[15:8]);
        put_byte(POS_ETYPE_LO, f.etype[7:0]);
        put_byte(POS_IHL, f.ver_ihl);
        put_byte(POS_TLEN_HI, f.tlen[15:8]);
        put_byte(POS_TLEN_LO, f.tlen[7:0]);
        put_byte(POS_PROTO, f.proto);
        for (int i = 0; i < 4; i++)
        begin
            put_byte(POS_SRC0 + i, f.src[8 * (3 - i) +: 8]);
            put_byte(POS_DST0 + i, f.dst[8 * (3 - i) +: 8]);
        end
        put_byte(s + OFS_PORT_HI, f.dport[15:8]);
        put_byte(s + OFS_PORT_LO, f.dport[7:0]);
        put_byte(s + OFS_FLAGS, f.flags);
    endfunction

    // One byte transfer; the sender idles between bursts of random length.
    task automatic xfer(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_spec_t f);
        compose(f);
        for (int i = 0; i < frame.size(); i++)
            xfer(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    // Stop sending and wait until every verdict due has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (chk_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_SIZE_THRESHOLD;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 9) < 6)
            return addr_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Mostly well-formed IPv4 frames with random content; the rest are short,
    // ARP, foreign ethertype, truncated or odd-IHL frames.
    task automatic random_frame();
        frame_spec_t f;
        int          roll;
        int          s;
        f = ip_frame(pick_addr(), pick_addr(), ok_ports[$urandom_range(0, 5)],
                     {2'($urandom_range(0, 3)), flag_picks[$urandom_range(0, 4)]});
        roll = $urandom_range(0, 99);
        if (roll < 8)
            f.len = $urandom_range(1, 13);
        else if (roll < 14)
        begin
            f.etype = ETH_ARP;
            f.len   = $urandom_range(14, 60);
        end
        else if (roll < 20)
        begin
            f.etype = 16'($urandom);
            f.len   = $urandom_range(14, 60);
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
                f.proto = proto_picks[$urandom_range(0, 3)];
            else if ($urandom_range(0, 9) == 0)
                f.proto = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                f.dst = f.src;
            if ($urandom_range(0, 9) < 3)
                f.dport = 16'($urandom);
            if ($urandom_range(0, 5) == 0)
                f.flags = 8'($urandom);
            case ($urandom_range(0, 3))
                0: f.tlen = 16'($urandom);
                1: f.tlen = cur_threshold;
                2: f.tlen = cur_threshold + 16'd1;
                default: f.tlen = 16'($urandom_range(20, 200));
            endcase
            roll = $urandom_range(0, 9);
            if (roll == 0)
                f.ver_ihl = 8'($urandom);
            else if (roll == 1)
                f.ver_ihl = {4'h4, 4'($urandom_range(6, 15))};
            s = int'(L4_OFFSET) + 4 * int'(f.ver_ihl[3:0]);
            roll = $urandom_range(0, 19);
            if (roll < 2)
                f.len = $urandom_range(14, s + OFS_FLAGS);
            else if (roll == 2)
                f.len = $urandom_range(POS_MAX, 160);
            else
                f.len = s + OFS_FLAGS + 1 + $urandom_range(0, 12);
        end
        send_frame(f);
    endtask

    // Result side: random stall patterns, plus long hold-offs on request.
    initial
    begin : receiver
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 300);
            end
            left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 4) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((left % 5) < 2);
            endcase
        end
    end

    // Ends the run if nothing moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        frame_spec_t f;
        logic [15:0] settings[4];
        logic [31:0] a;
        logic [31:0] b;

        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            addr_pool[i] = $urandom;
        a = 32'hC0A8_0001;
        b = 32'h0A00_0002;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_access(1'b0, '0);

        // Directed frames: header cut short, non-IP, truncation points.
        f = ip_frame(a, b, PORT_HTTP, {2'b00, FLAGS_ACK});
        f.len = 1;
        send_frame(f);
        f.len = 13;
        send_frame(f);
        f.etype = ETH_ARP;
        f.len = 14;
        send_frame(f);
        f.etype = 16'h86DD;
        f.len = 20;
        send_frame(f);
        f.etype = ETH_IPV4;
        f.len = 20;
        send_frame(f);
        f.len = 28;
        send_frame(f);
        f.len = 47;
        send_frame(f);

        // Each verdict in priority order; the port-scan source is then blacklisted.
        send_frame(ip_frame(a, b, PORT_HTTP, {2'b00, FLAGS_ACK}));
        send_frame(ip_frame(32'h0A0A_0A0A, 32'h0A0A_0A0A, PORT_HTTPS, {2'b00, FLAGS_ACK}));
        send_frame(ip_frame(32'h0B00_0001, b, 16'd8080, {2'b00, FLAGS_PSH_ACK}));
        send_frame(ip_frame(32'h0B00_0001, b, PORT_HTTP, {2'b00, FLAGS_PSH_ACK}));
        send_frame(ip_frame(32'h0B00_0002, b, PORT_SSH, {2'b11, FLAGS_XMAS}));
        send_frame(ip_frame(32'h0B00_0003, b, PORT_DNS, {2'b11, FLAGS_NULL}));
        f = ip_frame(32'h0B00_0004, b, PORT_FTP, 8'h02);
        f.tlen = 16'hFFFF;
        send_frame(f);
        f = ip_frame(32'h0B00_0005, b, PORT_FTP_DATA, {2'b00, FLAGS_PSH_ACK});
        f.tlen = 16'hFFFF;
        send_frame(f);
        f.flags = {2'b10, FLAGS_PSH};
        send_frame(f);

        // ICMP, IGMP, TCP and an unknown protocol on frames that end on the protocol
        // byte, extreme IHL values, a long frame, extreme addresses.
        f = ip_frame(a, b, PORT_DNS, {2'b00, FLAGS_ACK});
        f.len = 24;
        for (int i = 0; i < 4; i++)
        begin
            f.proto = (i == 3) ? 8'hFF : proto_picks[i];
            send_frame(f);
        end
        f.proto = PROTO_TCP;
        f.ver_ihl = 8'h40;
        f.len = 34;
        send_frame(f);
        f.ver_ihl = 8'h4F;
        f.len = 88;
        send_frame(f);
        f.ver_ihl = 8'h45;
        f.len = 130;
        send_frame(f);
        send_frame(ip_frame(32'hFFFF_FFFF, 32'h0000_0000, PORT_HTTPS, 8'hD0));
        wait_drained();

        // Random phases, one per threshold setting, extremes included.
        settings[0] = 16'h0000;
        settings[1] = 16'hFFFF;
        settings[2] = 16'($urandom);
        settings[3] = 16'($urandom_range(40, 120));
        for (int ph = 0; ph < 4; ph++)
        begin
            cur_threshold = settings[ph];
            reg_access(1'b1, {16'h0, cur_threshold});
            reg_access(1'b0, '0);
            settings_used++;
            case (ph)
                0: gap_max = 0;
                1: gap_max = 6;
                2: gap_max = 20;
                default: gap_max = 3;
            endcase

            // Hold the results off while short frames keep arriving.
            if (ph == 2)
            begin
                hold_request = 1'b1;
                for (int i = 0; i < 12; i++)
                begin
                    f.len = $urandom_range(1, 4);
                    send_frame(f);
                end
            end

            for (int i = 0; i < PHASE_FRAMES || (ph == 3 && bytes_sent < 1150); i++)
                random_frame();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d frames (%0d bytes) under %0d size thresholds.",
                 frames_sent, bytes_sent, settings_used);
        $display("Checked %0d verdicts; %0d sources went onto the blacklist.",
                 chk_checked, chk_inserts);
        if (chk_errors == 0 && chk_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
